@@ src/pnp_pkg.sv @@
// ----------------------------------------------------------------------------
// Pitch name parser package
// Token classes, the token record carried from front to back, queue status
// and shared constants.
// ----------------------------------------------------------------------------
`default_nettype none

package pnp_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [14:0] ERR_PITCH   = 15'd9600;
	localparam logic [6:0]  CENTS_LIMIT = 7'd100;
	localparam logic [14:0] OCT_STEP    = 15'd1200;
	localparam logic [14:0] OCT_BIAS    = 15'd4;
	localparam logic [14:0] PITCH_MIN   = 15'd4500;
	localparam logic [14:0] PITCH_MAX   = 15'd17000;

	typedef enum logic [3:0] {
		TK_END,
		TK_SPACE,
		TK_WS,
		TK_LETTER,
		TK_SHARP,
		TK_FLAT,
		TK_DSHARP,
		TK_PLUS,
		TK_MINUS,
		TK_DIGIT,
		TK_OTHER
	} tok_class_t;

	typedef struct packed {
		tok_class_t  cls;
		logic [3:0]  val;
	} token_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [3:0] letter_semis(input logic [2:0] idx);
		logic [3:0] s;
		unique case (idx)
			3'd0:    s = 4'd9;
			3'd1:    s = 4'd11;
			3'd2:    s = 4'd0;
			3'd3:    s = 4'd2;
			3'd4:    s = 4'd4;
			3'd5:    s = 4'd5;
			3'd6:    s = 4'd7;
			default: s = 4'd0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

@@ src/pnp_front.sv @@
// ----------------------------------------------------------------------------
// Pitch name parser front end
// Accepts one byte per transaction and classifies it into a token.
// ----------------------------------------------------------------------------
`default_nettype none

module pnp_front
	import pnp_pkg::*;
(
	input  wire logic       in_valid,
	input  wire logic [7:0] char_code,
	input  wire q_status_t  q_status,
	output logic            in_stall,
	output logic            push,
	output token_t          push_tok
);

	localparam logic [7:0] CH_NUL    = 8'd0;
	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_SHARP  = 8'd35;
	localparam logic [7:0] CH_PLUS   = 8'd43;
	localparam logic [7:0] CH_MINUS  = 8'd45;
	localparam logic [7:0] CH_ZERO   = 8'd48;
	localparam logic [7:0] CH_NINE   = 8'd57;
	localparam logic [7:0] CH_A      = 8'd65;
	localparam logic [7:0] CH_G      = 8'd71;
	localparam logic [7:0] CH_FLAT   = 8'd98;
	localparam logic [7:0] CH_DSHARP = 8'd120;

	logic [7:0] dig_off;
	logic [7:0] let_off;

	assign in_stall = q_status.full;
	assign push     = in_valid & ~q_status.full;
	assign dig_off  = char_code - CH_ZERO;
	assign let_off  = char_code - CH_A;

	always_comb begin
		push_tok.val = 4'd0;
		unique case (char_code) inside
			CH_NUL:              push_tok.cls = TK_END;
			CH_SPACE:            push_tok.cls = TK_SPACE;
			[CH_TAB:CH_CR]:      push_tok.cls = TK_WS;
			[CH_A:CH_G]: begin
				push_tok.cls = TK_LETTER;
				push_tok.val = letter_semis(let_off[2:0]);
			end
			CH_SHARP:            push_tok.cls = TK_SHARP;
			CH_FLAT:             push_tok.cls = TK_FLAT;
			CH_DSHARP:           push_tok.cls = TK_DSHARP;
			CH_PLUS:             push_tok.cls = TK_PLUS;
			CH_MINUS:            push_tok.cls = TK_MINUS;
			[CH_ZERO:CH_NINE]: begin
				push_tok.cls = TK_DIGIT;
				push_tok.val = dig_off[3:0];
			end
			default:             push_tok.cls = TK_OTHER;
		endcase
	end

endmodule

`default_nettype wire

@@ src/pnp_queue.sv @@
// ----------------------------------------------------------------------------
// Pitch name parser token queue
// Short queue between front and back so that each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module pnp_queue
	import pnp_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire token_t push_tok,
	input  wire logic   pop,
	output q_status_t   q_status,
	output token_t      head_tok
);

	token_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign q_status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);
	assign head_tok       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full && !pop |=> count_q == QCNT_W'(QUEUE_DEPTH))
		else $error("queue count moved while full without a pop");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ src/pnp_back.sv @@
// ----------------------------------------------------------------------------
// Pitch name parser back end
// Parses one name token per cycle while pop is high and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pnp_back
	import pnp_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire q_status_t q_status,
	input  wire token_t head_tok,
	input  wire logic   out_stall,
	output logic        pop,
	output logic        out_valid,
	output logic [14:0] pitch_cents,
	output logic        invalid
);

	typedef enum logic [2:0] {
		PH_LETTER,
		PH_ACC,
		PH_FLAT2,
		PH_OCTAVE,
		PH_IDLE,
		PH_WS,
		PH_SIGN,
		PH_DIGITS
	} phase_t;

	phase_t             phase_q;
	logic signed [4:0]  semi_q;
	logic [3:0]         oct_q;
	logic [6:0]         mag_q;
	logic               neg_q;
	logic               seen_q;
	logic               err_q;
	logic               out_valid_q;
	logic [14:0]        pitch_q;
	logic               invalid_q;

	logic               is_end;
	logic               bad;
	logic [9:0]         mag_next_w;
	logic [6:0]         mag_next;
	logic [14:0]        base;
	logic signed [15:0] semi_term;
	logic signed [15:0] cents_term;
	logic signed [15:0] pitch_sum;

	assign is_end      = (head_tok.cls == TK_END);
	assign pop         = !q_status.empty && (!is_end || !out_valid_q || !out_stall);
	assign out_valid   = out_valid_q;
	assign pitch_cents = pitch_q;
	assign invalid     = invalid_q;

	assign mag_next_w = 10'(mag_q) * 10'd10 + 10'(head_tok.val);
	assign mag_next   = (mag_next_w > 10'(CENTS_LIMIT)) ? CENTS_LIMIT + 7'd1 : mag_next_w[6:0];

	assign bad = err_q || (phase_q == PH_LETTER) || (phase_q == PH_ACC)
		|| (phase_q == PH_FLAT2) || (phase_q == PH_OCTAVE) || (phase_q == PH_WS)
		|| (phase_q == PH_SIGN) || ((phase_q == PH_DIGITS) && !seen_q)
		|| (mag_q > CENTS_LIMIT);

	assign base       = (15'(oct_q) + OCT_BIAS) * OCT_STEP;
	assign semi_term  = 16'(semi_q * 16'sd100);
	assign cents_term = (phase_q != PH_DIGITS) ? 16'sd0 :
		neg_q ? -$signed(16'(mag_q)) : $signed(16'(mag_q));
	assign pitch_sum  = $signed({1'b0, base}) + semi_term + cents_term;

	always_ff @(posedge clk) begin
		if (pop && is_end) begin
			pitch_q   <= bad ? ERR_PITCH : pitch_sum[14:0];
			invalid_q <= bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LETTER;
			semi_q      <= '0;
			oct_q       <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			seen_q      <= 1'b0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && is_end) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (is_end) begin
					phase_q <= PH_LETTER;
					semi_q  <= '0;
					oct_q   <= '0;
					mag_q   <= '0;
					neg_q   <= 1'b0;
					seen_q  <= 1'b0;
					err_q   <= 1'b0;
				end else if (err_q) begin
					// drop bytes until end of name
				end else if (head_tok.cls == TK_SPACE && phase_q <= PH_IDLE) begin
					// skip
				end else begin
					unique case (phase_q)
						PH_LETTER: begin
							if (head_tok.cls == TK_LETTER) begin
								semi_q  <= $signed({1'b0, head_tok.val});
								phase_q <= PH_ACC;
							end else begin
								err_q <= 1'b1;
							end
						end
						PH_ACC, PH_FLAT2, PH_OCTAVE: begin
							if (phase_q == PH_ACC && head_tok.cls == TK_SHARP) begin
								semi_q  <= semi_q + 5'sd1;
								phase_q <= PH_FLAT2;
							end else if (phase_q == PH_ACC && head_tok.cls == TK_FLAT) begin
								semi_q  <= semi_q - 5'sd1;
								phase_q <= PH_FLAT2;
							end else if (phase_q == PH_ACC && head_tok.cls == TK_DSHARP) begin
								semi_q  <= semi_q + 5'sd2;
								phase_q <= PH_FLAT2;
							end else if (phase_q == PH_FLAT2 && head_tok.cls == TK_FLAT) begin
								semi_q  <= semi_q - 5'sd1;
								phase_q <= PH_OCTAVE;
							end else if (head_tok.cls == TK_DIGIT) begin
								oct_q   <= head_tok.val;
								phase_q <= PH_IDLE;
							end else begin
								err_q <= 1'b1;
							end
						end
						PH_IDLE, PH_WS: begin
							if (head_tok.cls == TK_SPACE || head_tok.cls == TK_WS) begin
								phase_q <= PH_WS;
							end else if (head_tok.cls == TK_PLUS) begin
								phase_q <= PH_SIGN;
							end else if (head_tok.cls == TK_MINUS) begin
								neg_q   <= 1'b1;
								phase_q <= PH_SIGN;
							end else if (head_tok.cls == TK_DIGIT) begin
								mag_q   <= mag_next;
								seen_q  <= 1'b1;
								phase_q <= PH_DIGITS;
							end else begin
								err_q <= 1'b1;
							end
						end
						PH_SIGN, PH_DIGITS: begin
							if (head_tok.cls == TK_DIGIT) begin
								mag_q   <= mag_next;
								seen_q  <= 1'b1;
								phase_q <= PH_DIGITS;
							end else begin
								err_q <= 1'b1;
							end
						end
						default: begin
							err_q <= 1'b1;
						end
					endcase
				end
			end
		end
	end

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		pop && is_end |=> phase_q == PH_LETTER && !err_q && out_valid_q)
		else $error("end of name did not restart the parser");

	a_err_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && invalid_q |-> pitch_q == ERR_PITCH)
		else $error("invalid result without error pitch");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !invalid_q |-> pitch_q >= PITCH_MIN && pitch_q <= PITCH_MAX)
		else $error("pitch out of range");

endmodule

`default_nettype wire

@@ src/pitch_name_parser.sv @@
// A zero byte passes through the token queue; popping it loads the output register.
// Throughput: one byte per cycle unless in_stall; the parser retires one queued token
// per cycle unless empty or stalled; a name's result holds only the output register.
// A waiting result stalls the back end only when the next token is also an end of name.
// Reset: arst_n clears the queue, the parse state and the output valid at once.
// ----------------------------------------------------------------------------
// Pitch name parser
// Reads a pitch name byte by byte and gives its pitch in cents.
// ----------------------------------------------------------------------------
`default_nettype none

module pitch_name_parser
	import pnp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  char_code,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [14:0]      pitch_cents,
	output logic             invalid
);

	q_status_t q_status;
	logic      push;
	logic      pop;
	token_t    push_tok;
	token_t    head_tok;

	pnp_front u_front (
		.in_valid (in_valid),
		.char_code(char_code),
		.q_status (q_status),
		.in_stall (in_stall),
		.push     (push),
		.push_tok (push_tok)
	);

	pnp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_tok(push_tok),
		.pop     (pop),
		.q_status(q_status),
		.head_tok(head_tok)
	);

	pnp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_status   (q_status),
		.head_tok   (head_tok),
		.out_stall  (out_stall),
		.pop        (pop),
		.out_valid  (out_valid),
		.pitch_cents(pitch_cents),
		.invalid    (invalid)
	);

endmodule

`default_nettype wire
